// ----- hdl/vbcp_pkg.sv -----
// Shared constants, pipeline side-band type and saturation helpers for the velocity bounce core.
package vbcp_pkg;

	localparam int NORM_FRAC_BITS = 14;

	localparam int DIVA_STEPS = 48;
	localparam int DIVA_NUM_W = 58;
	localparam int DIVA_DEN_W = 16;
	localparam int DIVA_REM_W = DIVA_DEN_W + 1;
	localparam int BMAG_W = DIVA_STEPS - NORM_FRAC_BITS;
	localparam int CPROD_W = BMAG_W + 16;
	localparam int CH_W = CPROD_W - NORM_FRAC_BITS;

	localparam int SQRT_STEPS = 32;

	localparam int DIVB_STEPS = 33;
	localparam int DIVB_NUM_W = 63;
	localparam int DIVB_REM_W = 32;

	localparam logic [10:0] OVB_UP = 11'd1001;
	localparam logic [10:0] OVB_DN = 11'd1000;

	typedef enum logic {
		MODE_CLIP = 1'b0,
		MODE_PROJECT = 1'b1
	} bounce_mode_t;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		bounce_mode_t mode;
		logic pre;
		logic dneg;
		logic go;
		logic nneg;
		logic [31:0] r;
		logic [30:0] bx;
		logic [30:0] by;
		logic [30:0] bn;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
	} side_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic [15:0] mag16(input logic signed [15:0] v);
		return v[15] ? 16'(-v) : 16'(v);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647) begin
			return 32'sh7fffffff;
		end
		if (v < -40'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] sat_mag(input logic [32:0] q, input logic neg);
		logic [32:0] t;
		t = (~q) + 33'd1;
		if (neg) begin
			if (q > 33'h080000000) begin
				return 32'sh80000000;
			end
			return t[31:0];
		end
		if (q > 33'h07fffffff) begin
			return 32'sh7fffffff;
		end
		return q[31:0];
	endfunction

endpackage

// ----- hdl/velocity_bounce_clip_project_core.sv -----
// Top level of the velocity bounce core: a fully pipelined clip and slope projection datapath.
// The core takes one velocity and normal per cycle and returns one bounced velocity per item,
// in input order. Latency is set by the longest chain,
// a 48-step divider feeding a 32-step square root and a 33-step divider, all unrolled into
// register stages, so a new transfer is taken every cycle unless the output is held off, which
// stalls the whole pipeline. bounce_mode selects clip (0) or slope projection (1); write it only
// while no items are in flight.
module velocity_bounce_clip_project_core
	import vbcp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,  // vel_x, vel_y, vel_z, norm_x, norm_y, norm_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata,  // out_x, out_y, out_z
	output logic         m_axis_tuser   // written
);

	bounce_mode_t mode_q;
	logic adv;

	logic vld_s1, vld_s2, vld_s3, vld_s5, vld_s6, vld_s7, vld_s8, vld_s11;
	side_t side_s1, side_s2, side_s3, side_s5, side_s6, side_s7, side_s8;
	side_t in_side;

	logic signed [47:0] p_s2 [3];
	logic [63:0] sq_s2 [3];
	logic signed [27:0] nzk;

	logic [47:0] dmag_s3;
	logic [63:0] sumsq_s3;
	logic signed [49:0] dsum;

	logic [DIVA_NUM_W-1:0] dva_num_s [0:DIVA_STEPS];
	logic [DIVA_DEN_W-1:0] dva_den_s [0:DIVA_STEPS];
	logic [DIVA_REM_W-1:0] dva_rem_s [0:DIVA_STEPS];
	logic [DIVA_STEPS-1:0] dva_q_s [0:DIVA_STEPS];
	side_t dva_side_s [0:DIVA_STEPS];
	logic dva_vld_s [0:DIVA_STEPS];
	logic [63:0] sqa_x_s [0:DIVA_STEPS];
	logic [63:0] sqa_res_s [0:DIVA_STEPS];
	logic [DIVA_NUM_W-1:0] num_a;

	logic [CPROD_W-1:0] cprod_s5 [3];
	logic [2:0] cneg_s5;
	logic [DIVA_STEPS-1:0] an_s5, an_s6;
	logic [DIVA_STEPS-1:0] t_s5;
	logic [4:0] sh_s6;
	logic [4:0] sh_calc;
	logic signed [31:0] oc [3];
	logic [61:0] bsq_s8 [3];

	logic [63:0] sqb_x_s [0:SQRT_STEPS];
	logic [63:0] sqb_res_s [0:SQRT_STEPS];
	side_t sqb_side_s [0:SQRT_STEPS];
	logic sqb_vld_s [0:SQRT_STEPS];

	logic [DIVB_NUM_W-1:0] dvb_num_s [0:DIVB_STEPS][3];
	logic [DIVB_REM_W-1:0] dvb_rem_s [0:DIVB_STEPS][3];
	logic [DIVB_STEPS-1:0] dvb_q_s [0:DIVB_STEPS][3];
	logic [31:0] dvb_den_s [0:DIVB_STEPS];
	side_t dvb_side_s [0:DIVB_STEPS];
	logic dvb_vld_s [0:DIVB_STEPS];
	logic [31:0] m_root;

	logic signed [31:0] ox_s11, oy_s11, oz_s11;
	logic wr_s11;

	assign cfg_ready = 1'b1;
	assign adv = !vld_s11 || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CLIP;
		end else if (cfg_valid) begin
			mode_q <= bounce_mode_t'(cfg_data);
		end
	end

	always_comb begin
		in_side = '0;
		in_side.vx = s_axis_tdata[31:0];
		in_side.vy = s_axis_tdata[63:32];
		in_side.vz = s_axis_tdata[95:64];
		in_side.nx = s_axis_tdata[111:96];
		in_side.ny = s_axis_tdata[127:112];
		in_side.nz = s_axis_tdata[143:128];
		in_side.mode = mode_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			dva_vld_s[0] <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			sqb_vld_s[0] <= 1'b0;
			dvb_vld_s[0] <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			dva_vld_s[0] <= vld_s3;
			vld_s5 <= dva_vld_s[DIVA_STEPS];
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			sqb_vld_s[0] <= vld_s8;
			dvb_vld_s[0] <= sqb_vld_s[SQRT_STEPS];
			vld_s11 <= dvb_vld_s[DIVB_STEPS];
		end
	end

	// Products and squares.
	assign nzk = side_s1.nz * 28'sd1000;

	always_ff @(posedge clk) begin
		side_t nxt;
		nxt = side_s1;
		nxt.pre = (nzk >= $signed(28'(2 ** NORM_FRAC_BITS)))
			&& (side_s1.vx != 32'sd0 || side_s1.vy != 32'sd0);
		if (adv) begin
			side_s1 <= in_side;
			side_s2 <= nxt;
			p_s2[0] <= side_s1.vx * side_s1.nx;
			p_s2[1] <= side_s1.vy * side_s1.ny;
			p_s2[2] <= side_s1.vz * side_s1.nz;
			sq_s2[0] <= mag32(side_s1.vx) * mag32(side_s1.vx);
			sq_s2[1] <= mag32(side_s1.vy) * mag32(side_s1.vy);
			sq_s2[2] <= mag32(side_s1.vz) * mag32(side_s1.vz);
		end
	end

	// Dot product (without the z term in projection mode) and numerator of the first divider.
	assign dsum = 50'(p_s2[0]) + 50'(p_s2[1])
		+ ((side_s2.mode == MODE_CLIP) ? 50'(p_s2[2]) : 50'sd0);
	assign num_a = (side_s3.mode == MODE_PROJECT) ? DIVA_NUM_W'(dmag_s3)
		: DIVA_NUM_W'(dmag_s3) * DIVA_NUM_W'(side_s3.dneg ? OVB_UP : OVB_DN);

	always_ff @(posedge clk) begin
		side_t nxt;
		nxt = side_s2;
		nxt.dneg = dsum[49];
		if (adv) begin
			side_s3 <= nxt;
			dmag_s3 <= dsum[49] ? 48'(-dsum) : 48'(dsum);
			sumsq_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];

			dva_side_s[0] <= side_s3;
			dva_num_s[0] <= num_a;
			dva_den_s[0] <= (side_s3.mode == MODE_PROJECT) ? DIVA_DEN_W'($unsigned(side_s3.nz))
				: DIVA_DEN_W'(side_s3.dneg ? OVB_DN : OVB_UP);
			dva_rem_s[0] <= DIVA_REM_W'(num_a >> DIVA_STEPS);
			dva_q_s[0] <= '0;
			sqa_x_s[0] <= sumsq_s3;
			sqa_res_s[0] <= '0;
		end
	end

	// Overbounce / slope divider with the speed root alongside.
	for (genvar i = 0; i < DIVA_STEPS; i++) begin : g_dva
		localparam int J = DIVA_STEPS - 1 - i;
		logic [DIVA_REM_W:0] trial;
		assign trial = {dva_rem_s[i], dva_num_s[i][J]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dva_vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				dva_vld_s[i+1] <= dva_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dva_num_s[i+1] <= dva_num_s[i];
				dva_den_s[i+1] <= dva_den_s[i];
				dva_side_s[i+1] <= dva_side_s[i];
				if (trial >= {1'b0, 1'b0, dva_den_s[i]}) begin
					dva_rem_s[i+1] <= DIVA_REM_W'(trial - {1'b0, 1'b0, dva_den_s[i]});
					dva_q_s[i+1] <= {dva_q_s[i][DIVA_STEPS-2:0], 1'b1};
				end else begin
					dva_rem_s[i+1] <= trial[DIVA_REM_W-1:0];
					dva_q_s[i+1] <= {dva_q_s[i][DIVA_STEPS-2:0], 1'b0};
				end
			end
		end

		if (i < SQRT_STEPS) begin : g_sq
			localparam logic [63:0] BITV = 64'd1 << (62 - 2 * i);
			logic [64:0] tst;
			assign tst = {1'b0, sqa_res_s[i]} + {1'b0, BITV};
			always_ff @(posedge clk) begin
				if (adv) begin
					if ({1'b0, sqa_x_s[i]} >= tst) begin
						sqa_x_s[i+1] <= sqa_x_s[i] - tst[63:0];
						sqa_res_s[i+1] <= (sqa_res_s[i] >> 1) + BITV;
					end else begin
						sqa_x_s[i+1] <= sqa_x_s[i];
						sqa_res_s[i+1] <= sqa_res_s[i] >> 1;
					end
				end
			end
		end else begin : g_sqp
			always_ff @(posedge clk) begin
				if (adv) begin
					sqa_x_s[i+1] <= sqa_x_s[i];
					sqa_res_s[i+1] <= sqa_res_s[i];
				end
			end
		end
	end

	// Clip products, projection decision and largest magnitude.
	always_ff @(posedge clk) begin
		logic [DIVA_STEPS-1:0] q1;
		logic [DIVA_STEPS-1:0] ax, ay;
		logic [BMAG_W-1:0] bmag;
		side_t sd;
		logic nneg;
		logic vzpos;
		q1 = dva_q_s[DIVA_STEPS];
		sd = dva_side_s[DIVA_STEPS];
		ax = DIVA_STEPS'(mag32(sd.vx));
		ay = DIVA_STEPS'(mag32(sd.vy));
		bmag = BMAG_W'(q1 >> NORM_FRAC_BITS);
		nneg = !sd.dneg && (q1 != '0);
		vzpos = !sd.vz[31] && (sd.vz != 32'sd0);
		sd.r = sqa_res_s[DIVA_STEPS][31:0];
		sd.nneg = nneg;
		sd.go = sd.pre
			&& ((DIVA_STEPS'(mag32(sd.vz)) < q1) || nneg || vzpos);
		if (adv) begin
			side_s5 <= sd;
			cprod_s5[0] <= mag16(sd.nx) * bmag;
			cprod_s5[1] <= mag16(sd.ny) * bmag;
			cprod_s5[2] <= mag16(sd.nz) * bmag;
			cneg_s5 <= {sd.nz[15] ^ sd.dneg, sd.ny[15] ^ sd.dneg, sd.nx[15] ^ sd.dneg};
			an_s5 <= q1;
			if (ax >= ay && ax >= q1) begin
				t_s5 <= ax;
			end else if (ay >= q1) begin
				t_s5 <= ay;
			end else begin
				t_s5 <= q1;
			end
		end
	end

	always_comb begin
		logic [CH_W-1:0] ch;
		logic signed [39:0] chs;
		logic signed [31:0] vel [3];
		vel[0] = side_s5.vx;
		vel[1] = side_s5.vy;
		vel[2] = side_s5.vz;
		for (int k = 0; k < 3; k++) begin
			ch = CH_W'(cprod_s5[k] >> NORM_FRAC_BITS);
			chs = cneg_s5[k] ? -$signed(40'(ch)) : $signed(40'(ch));
			oc[k] = sat32(40'(vel[k]) - chs);
		end
		sh_calc = '0;
		for (int k = 31; k < DIVA_STEPS; k++) begin
			if (t_s5[k]) begin
				sh_calc = 5'(k - 30);
			end
		end
	end

	// Clip result, normalizing shift, scaled components and their squares.
	always_ff @(posedge clk) begin
		side_t s6n;
		side_t s7n;
		s6n = side_s5;
		s6n.ox = oc[0];
		s6n.oy = oc[1];
		s6n.oz = oc[2];
		s7n = side_s6;
		s7n.bx = 31'(mag32(side_s6.vx) >> sh_s6);
		s7n.by = 31'(mag32(side_s6.vy) >> sh_s6);
		s7n.bn = 31'(an_s6 >> sh_s6);
		if (adv) begin
			side_s6 <= s6n;
			sh_s6 <= sh_calc;
			an_s6 <= an_s5;

			side_s7 <= s7n;

			side_s8 <= side_s7;
			bsq_s8[0] <= side_s7.bx * side_s7.bx;
			bsq_s8[1] <= side_s7.by * side_s7.by;
			bsq_s8[2] <= side_s7.bn * side_s7.bn;

			sqb_side_s[0] <= side_s8;
			sqb_x_s[0] <= 64'(bsq_s8[0]) + 64'(bsq_s8[1]) + 64'(bsq_s8[2]);
			sqb_res_s[0] <= '0;
		end
	end

	// Root of the scaled direction length.
	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqb
		localparam logic [63:0] BITV = 64'd1 << (62 - 2 * i);
		logic [64:0] tst;
		assign tst = {1'b0, sqb_res_s[i]} + {1'b0, BITV};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqb_vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				sqb_vld_s[i+1] <= sqb_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sqb_side_s[i+1] <= sqb_side_s[i];
				if ({1'b0, sqb_x_s[i]} >= tst) begin
					sqb_x_s[i+1] <= sqb_x_s[i] - tst[63:0];
					sqb_res_s[i+1] <= (sqb_res_s[i] >> 1) + BITV;
				end else begin
					sqb_x_s[i+1] <= sqb_x_s[i];
					sqb_res_s[i+1] <= sqb_res_s[i] >> 1;
				end
			end
		end
	end

	// Speed times each scaled component, then three dividers by the root.
	assign m_root = (sqb_res_s[SQRT_STEPS][31:0] == 32'd0) ? 32'd1
		: sqb_res_s[SQRT_STEPS][31:0];

	always_ff @(posedge clk) begin
		side_t sd;
		sd = sqb_side_s[SQRT_STEPS];
		if (adv) begin
			dvb_side_s[0] <= sd;
			dvb_den_s[0] <= m_root;
			dvb_num_s[0][0] <= sd.r * sd.bx;
			dvb_num_s[0][1] <= sd.r * sd.by;
			dvb_num_s[0][2] <= sd.r * sd.bn;
			for (int k = 0; k < 3; k++) begin
				dvb_rem_s[0][k] <= '0;
				dvb_q_s[0][k] <= '0;
			end
		end
	end

	for (genvar i = 0; i < DIVB_STEPS; i++) begin : g_dvb
		localparam int J = DIVB_STEPS - 1 - i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvb_vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				dvb_vld_s[i+1] <= dvb_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			logic [DIVB_REM_W:0] trial;
			logic [DIVB_REM_W-1:0] part;
			if (adv) begin
				dvb_side_s[i+1] <= dvb_side_s[i];
				dvb_den_s[i+1] <= dvb_den_s[i];
				for (int k = 0; k < 3; k++) begin
					part = (i == 0) ? DIVB_REM_W'(dvb_num_s[i][k] >> DIVB_STEPS)
						: dvb_rem_s[i][k];
					trial = {part, dvb_num_s[i][k][J]};
					dvb_num_s[i+1][k] <= dvb_num_s[i][k];
					if (trial >= {1'b0, dvb_den_s[i]}) begin
						dvb_rem_s[i+1][k] <= DIVB_REM_W'(trial - {1'b0, dvb_den_s[i]});
						dvb_q_s[i+1][k] <= {dvb_q_s[i][k][DIVB_STEPS-2:0], 1'b1};
					end else begin
						dvb_rem_s[i+1][k] <= trial[DIVB_REM_W-1:0];
						dvb_q_s[i+1][k] <= {dvb_q_s[i][k][DIVB_STEPS-2:0], 1'b0};
					end
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		side_t sd;
		sd = dvb_side_s[DIVB_STEPS];
		if (adv) begin
			if (sd.mode == MODE_CLIP) begin
				ox_s11 <= sd.ox;
				oy_s11 <= sd.oy;
				oz_s11 <= sd.oz;
				wr_s11 <= 1'b1;
			end else if (!sd.go) begin
				ox_s11 <= sd.vx;
				oy_s11 <= sd.vy;
				oz_s11 <= sd.vz;
				wr_s11 <= 1'b0;
			end else begin
				ox_s11 <= sat_mag(dvb_q_s[DIVB_STEPS][0], sd.vx[31]);
				oy_s11 <= sat_mag(dvb_q_s[DIVB_STEPS][1], sd.vy[31]);
				oz_s11 <= sat_mag(dvb_q_s[DIVB_STEPS][2], sd.nneg);
				wr_s11 <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = vld_s11;
	assign m_axis_tdata = {oz_s11, oy_s11, ox_s11};
	assign m_axis_tuser = wr_s11;

endmodule

// ----- hdl/vbcp_checker.sv -----
// Port-level checker for the velocity bounce core and its bind to the top level.
module vbcp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [95:0]  m_axis_tdata,
	input logic         m_axis_tuser
);

	logic [7:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 8'(s_axis_tvalid && s_axis_tready)
				- 8'(m_axis_tvalid && m_axis_tready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("Output valid dropped before its transfer.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("Output payload changed while stalled.");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> cnt_q != 8'd0)
		else $error("Result shown with no item in flight.");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("Input held off while the output side is ready.");

endmodule

bind velocity_bounce_clip_project_core vbcp_checker u_vbcp_checker (.*);
